### rtl/segps_pkg.sv
// Shared constants and types for the segmented prime sieve.
package segps_pkg;

   localparam int SEG_LEN_DEF    = 64;
   localparam int MAX_PRIMES_DEF = 4096;

   localparam int VALUE_W  = 48;
   localparam int PRIME_W  = 24;
   localparam int LENGTH_W = 7;
   localparam int OP_W     = 2;

   // Operation codes carried in req_tuser
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_SIEVE = 2'd2;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_READ   = 8'b0000_0010,
      ST_FETCH  = 8'b0000_0100,
      ST_MOD    = 8'b0000_1000,
      ST_FIRST  = 8'b0001_0000,
      ST_STRIKE = 8'b0010_0000,
      ST_SCAN   = 8'b0100_0000,
      ST_EMPTY  = 8'b1000_0000
   } state_type;

endpackage

### rtl/segps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module segps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/segmented_prime_sieve.sv
// Top level of the segmented prime sieve: prime table RAM, sieve sequencer, result register.
// Clear and load items are taken on acceptance; the block is ready again the next cycle.
// A sieve item walks the stored primes: read, fetch, bit-serial remainder of the start, first
// multiple, then one strike per multiple in the segment (at most the length); entries below 2
// go on after the fetch. The scan then emits survivors, held by output stalls. One item at a time.
// Reset (synchronous, active high) clears the state, prime count and result valid flag; table undefined.
module segmented_prime_sieve #(
   parameter int SEG_LEN    = segps_pkg::SEG_LEN_DEF,
   parameter int MAX_PRIMES = segps_pkg::MAX_PRIMES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // prime[23:0], seg_start[71:24], seg_length[78:72], 0
   input  logic [1:0]   req_tuser,   // operation[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // value[47:0]
   output logic         rsp_tuser,   // valid_res[0]
   output logic         rsp_tlast
);

   localparam int AW    = $clog2(MAX_PRIMES);
   localparam int CNTW  = $clog2(MAX_PRIMES + 1);
   localparam int IDXW  = $clog2(SEG_LEN);
   localparam int LENW  = $clog2(SEG_LEN + 1);
   localparam int VW    = segps_pkg::VALUE_W;
   localparam int PW    = segps_pkg::PRIME_W;
   localparam int BITW  = $clog2(VW);

   segps_pkg::state_type state_ff, state_in;

   logic [CNTW-1:0]    count_ff, count_in;
   logic [CNTW-1:0]    j_ff, j_in;
   logic [VW-1:0]      start_ff, start_in;
   logic [LENW-1:0]    len_ff, len_in;
   logic [SEG_LEN-1:0] flags_ff, flags_in;
   logic [PW-1:0]      p_ff, p_in;
   logic [PW-1:0]      rem_ff, rem_in;
   logic [BITW-1:0]    bit_ff, bit_in;
   logic [LENW-1:0]    off_ff, off_in;
   logic [IDXW-1:0]    idx_ff, idx_in;

   logic               out_valid_ff, out_valid_in;
   logic [VW-1:0]      out_value_ff, out_value_in;
   logic               out_res_ff, out_res_in;
   logic               out_last_ff, out_last_in;

   logic [1:0]         req_op;
   logic [PW-1:0]      req_prime;
   logic [VW-1:0]      req_start;
   logic [6:0]         req_length;
   logic               req_fire;
   logic               out_free;

   logic               ram_wr;
   logic [PW-1:0]      ram_rd_data;

   logic [6:0]         len_sat;
   logic [VW:0]        room;
   logic [LENW-1:0]    len_clip;
   logic [SEG_LEN-1:0] flags_init;

   logic [PW:0]        rem_shift;
   logic [PW-1:0]      rem_step;
   logic [PW-1:0]      round_up;
   logic [VW:0]        first_up;
   logic [VW:0]        twice;
   logic [VW:0]        first_mul;
   logic [VW:0]        first_off;
   logic [PW:0]        next_off;
   logic [CNTW-1:0]    j_next;
   logic [SEG_LEN-1:0] flags_rest;

   // Unpack the request item
   assign req_op     = req_tuser;
   assign req_prime  = req_tdata[23:0];
   assign req_start  = req_tdata[71:24];
   assign req_length = req_tdata[78:72];

   assign req_tready = (state_ff == segps_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_res_ff;
   assign rsp_tlast  = out_last_ff;

   // Prime table
   assign ram_wr = req_fire && (req_op == segps_pkg::OP_LOAD) && (count_ff < CNTW'(MAX_PRIMES));

   segps_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_PRIMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_prime),
      .rd_addr (j_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Clip the segment length to SEG_LEN and to the value range
   always_comb begin
      len_sat  = (req_length > 7'(SEG_LEN)) ? 7'(SEG_LEN) : req_length;
      room     = {1'b1, {VW{1'b0}}} - {1'b0, req_start};
      len_clip = (room < (VW+1)'(len_sat)) ? room[LENW-1:0] : len_sat[LENW-1:0];
   end

   // Initial survivor flags: inside the segment and at least two
   always_comb begin
      for (int i = 0; i < SEG_LEN; i++) begin
         flags_init[i] = (LENW'(i) < len_clip) &&
                         ((req_start >= VW'(2)) ||
                          ((req_start == VW'(1)) && (i >= 1)) ||
                          (i >= 2));
      end
   end

   // Remainder step, first multiple and strike arithmetic
   always_comb begin
      rem_shift = {rem_ff, start_ff[bit_ff]};
      rem_step  = (rem_shift >= {1'b0, p_ff}) ? PW'(rem_shift - {1'b0, p_ff}) :
                                                 rem_shift[PW-1:0];
      round_up  = (rem_ff == '0) ? '0 : (p_ff - rem_ff);
      first_up  = {1'b0, start_ff} + (VW+1)'(round_up);
      twice     = (VW+1)'({p_ff, 1'b0});
      first_mul = (first_up < twice) ? twice : first_up;
      first_off = first_mul - {1'b0, start_ff};
      next_off  = (PW+1)'(off_ff) + (PW+1)'(p_ff);
      j_next    = j_ff + CNTW'(1);
      flags_rest = flags_ff & ~(SEG_LEN'(1) << idx_ff);
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      j_in         = j_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      flags_in     = flags_ff;
      p_in         = p_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      off_in       = off_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_res_in   = out_res_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         segps_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  segps_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  segps_pkg::OP_LOAD: begin
                     if (ram_wr) begin
                        count_in = count_ff + CNTW'(1);
                     end
                  end
                  segps_pkg::OP_SIEVE: begin
                     start_in = req_start;
                     len_in   = len_clip;
                     flags_in = flags_init;
                     j_in     = '0;
                     idx_in   = '0;
                     state_in = (count_ff == '0) ? segps_pkg::ST_SCAN : segps_pkg::ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         segps_pkg::ST_READ: begin
            state_in = segps_pkg::ST_FETCH;
         end
         segps_pkg::ST_FETCH: begin
            // Take the prime; skip entries below 2, which strike nothing
            p_in   = ram_rd_data;
            rem_in = '0;
            bit_in = BITW'(VW - 1);
            if (ram_rd_data < PW'(2)) begin
               j_in     = j_next;
               state_in = (j_next < count_ff) ? segps_pkg::ST_READ : segps_pkg::ST_SCAN;
            end else begin
               state_in = segps_pkg::ST_MOD;
            end
         end
         segps_pkg::ST_MOD: begin
            // One remainder bit a cycle, top bit first
            rem_in = rem_step;
            bit_in = bit_ff - BITW'(1);
            if (bit_ff == '0) begin
               state_in = segps_pkg::ST_FIRST;
            end
         end
         segps_pkg::ST_FIRST: begin
            if (first_off < (VW+1)'(len_ff)) begin
               off_in   = first_off[LENW-1:0];
               state_in = segps_pkg::ST_STRIKE;
            end else begin
               j_in     = j_next;
               state_in = (j_next < count_ff) ? segps_pkg::ST_READ : segps_pkg::ST_SCAN;
            end
         end
         segps_pkg::ST_STRIKE: begin
            // Strike one multiple a cycle
            flags_in[off_ff[IDXW-1:0]] = 1'b0;
            if (next_off < (PW+1)'(len_ff)) begin
               off_in = next_off[LENW-1:0];
            end else begin
               j_in     = j_next;
               state_in = (j_next < count_ff) ? segps_pkg::ST_READ : segps_pkg::ST_SCAN;
            end
         end
         segps_pkg::ST_SCAN: begin
            // Emit survivors in ascending order
            if (flags_ff == '0) begin
               state_in = segps_pkg::ST_EMPTY;
            end else if (flags_ff[idx_ff]) begin
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_value_in = start_ff + VW'(idx_ff);
                  out_res_in   = 1'b1;
                  out_last_in  = (flags_rest == '0);
                  flags_in     = flags_rest;
                  idx_in       = idx_ff + IDXW'(1);
                  if (flags_rest == '0) begin
                     state_in = segps_pkg::ST_IDLE;
                  end
               end
            end else begin
               idx_in = idx_ff + IDXW'(1);
            end
         end
         segps_pkg::ST_EMPTY: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = '0;
               out_res_in   = 1'b0;
               out_last_in  = 1'b1;
               state_in     = segps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = segps_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= segps_pkg::ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      start_ff     <= start_in;
      len_ff       <= len_in;
      flags_ff     <= flags_in;
      p_ff         <= p_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      off_ff       <= off_in;
      idx_ff       <= idx_in;
      out_value_ff <= out_value_in;
      out_res_ff   <= out_res_in;
      out_last_ff  <= out_last_in;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_PRIMES))
      else $error("prime count above table depth");

   a_strike_in_seg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == segps_pkg::ST_STRIKE) |-> (off_ff < len_ff))
      else $error("strike offset outside segment");

   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_res_ff) |-> out_last_ff)
      else $error("empty marker not marked last");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == segps_pkg::ST_SCAN && out_valid_in && out_last_in && out_free)
      |=> (state_ff == segps_pkg::ST_IDLE))
      else $error("sequencer busy after last result");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the segmented prime sieve: directed table, random items, predictor.
module testbench;

   localparam int SEG_MAX   = segps_pkg::SEG_LEN_DEF;
   localparam int TBL_DEPTH = segps_pkg::MAX_PRIMES_DEF;
   localparam longint unsigned VAL_LIMIT = 64'h1_0000_0000_0000;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int RANDOM_ITEMS = 80;

   // Operation code that the block ignores
   localparam logic [segps_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [segps_pkg::VALUE_W-1:0] value;
      logic                          found;
      logic                          last;
   } survivor_type;

   typedef struct {
      logic [segps_pkg::OP_W-1:0]     op;
      logic [segps_pkg::PRIME_W-1:0]  prime;
      logic [segps_pkg::VALUE_W-1:0]  start;
      logic [segps_pkg::LENGTH_W-1:0] len;
      bit                             typed;
      survivor_type                   want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [79:0]         req_tdata = '0;
   logic [1:0]          req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [47:0]         rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;

   // predictor state
   logic [segps_pkg::PRIME_W-1:0] mirror_table [TBL_DEPTH];
   int                  mirror_count;
   survivor_type        pending_survivors[$];
   stim_row_type        stim_rows[$];

   int  failures;
   int  sieves_sent;
   int  results_seen;
   int  items_sent;
   int  sender_idle_pct;
   int  receiver_stall_pct;
   longint cycles;

   segmented_prime_sieve u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Append one expected result
   function automatic void queue_expect(survivor_type s);
      pending_survivors = {pending_survivors, s};
   endfunction

   // Append one directed stimulus row
   function automatic void queue_row(stim_row_type r);
      stim_rows = {stim_rows, r};
   endfunction

   // Strike composites of one segment and queue its survivors
   function automatic void predict_segment(logic [segps_pkg::VALUE_W-1:0] start_in,
                                           logic [segps_pkg::LENGTH_W-1:0] len_in,
                                           bit keep);
      longint unsigned start, len, stop, p, first, k;
      logic [63:0]  alive;
      survivor_type item;
      int           found_n;
      start   = start_in;
      len     = len_in;
      alive   = '1;
      found_n = 0;
      if (len > SEG_MAX) len = SEG_MAX;
      if (len > VAL_LIMIT - start) len = VAL_LIMIT - start;
      stop = start + len;
      for (int j = 0; j < mirror_count; j++) begin
         p = mirror_table[j];
         if (p < 2) continue;
         first = ((start + p - 1) / p) * p;
         if (first < 2 * p) first = 2 * p;
         for (k = first; k < stop; k += p)
            if (k - start < 64) alive[k - start] = 1'b0;
      end
      if (!keep) return;
      for (int i = 0; i < len; i++) begin
         if (start + i >= 2 && alive[i]) begin
            item.value = segps_pkg::VALUE_W'(start + i);
            item.found = 1'b1;
            item.last  = 1'b0;
            queue_expect(item);
            found_n++;
         end
      end
      if (found_n == 0) begin
         item = '{value: '0, found: 1'b0, last: 1'b1};
         queue_expect(item);
      end else begin
         pending_survivors[pending_survivors.size() - 1].last = 1'b1;
      end
   endfunction

   // Update the mirrored table for an accepted item, or queue the expected results of a sieve
   function automatic void predict_item(stim_row_type row);
      case (row.op)
         segps_pkg::OP_CLEAR: mirror_count = 0;
         segps_pkg::OP_LOAD: begin
            if (mirror_count < TBL_DEPTH) begin
               mirror_table[mirror_count] = row.prime;
               mirror_count++;
            end
         end
         segps_pkg::OP_SIEVE: begin
            sieves_sent++;
            predict_segment(row.start, row.len, !row.typed);
            if (row.typed) queue_expect(row.want);
         end
         default: ;
      endcase
   endfunction

   // Present one item, idling at random first, and hold it until taken
   task automatic send_item(stim_row_type row);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.op;
      req_tdata  <= {1'b0, row.len, row.start, row.prime};
      do @(posedge clock); while (!req_tready);
      predict_item(row);
      items_sent++;
   endtask

   task automatic drain_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_survivors.size() != 0) @(posedge clock);
   endtask

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      survivor_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_survivors.size() == 0) begin
            $error("unexpected result value=%0d", rsp_tdata);
            failures++;
         end else begin
            want = pending_survivors.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("value: expected %0d got %0d", want.value, rsp_tdata);
               failures++;
            end
            if (rsp_tuser !== want.found) begin
               $error("valid_res: expected %0b got %0b", want.found, rsp_tuser);
               failures++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b got %0b", want.last, rsp_tlast);
               failures++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   function automatic stim_row_type mk(logic [segps_pkg::OP_W-1:0] op,
                                       logic [segps_pkg::PRIME_W-1:0] prime,
                                       logic [segps_pkg::VALUE_W-1:0] start,
                                       logic [segps_pkg::LENGTH_W-1:0] len);
      stim_row_type r;
      r.op = op; r.prime = prime; r.start = start; r.len = len;
      r.typed = 1'b0; r.want = '0;
      return r;
   endfunction

   function automatic stim_row_type mk_typed(logic [segps_pkg::VALUE_W-1:0] start,
                                             logic [segps_pkg::LENGTH_W-1:0] len,
                                             survivor_type want);
      stim_row_type r;
      r = mk(segps_pkg::OP_SIEVE, '0, start, len);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic stim_row_type random_row();
      int           pick;
      stim_row_type r;
      logic [segps_pkg::VALUE_W-1:0]  s;
      logic [segps_pkg::LENGTH_W-1:0] l;
      int small_primes [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
      pick = $urandom_range(99);
      case ($urandom_range(3))
         0: s = segps_pkg::VALUE_W'($urandom_range(2000));
         1: s = segps_pkg::VALUE_W'({$urandom, $urandom});
         2: s = 48'hFFFF_FFFF_FFFF - segps_pkg::VALUE_W'($urandom_range(80));
         default: s = segps_pkg::VALUE_W'($urandom_range(300));
      endcase
      l = ($urandom_range(9) == 0) ? segps_pkg::LENGTH_W'($urandom_range(127)) :
                                     segps_pkg::LENGTH_W'($urandom_range(1, SEG_MAX));
      r = mk(segps_pkg::OP_SIEVE, segps_pkg::PRIME_W'($urandom), s, l);
      if (pick < 8 || (pick < 45 && mirror_count > 20)) r.op = segps_pkg::OP_CLEAR;
      else if (pick < 45) begin
         r.op = segps_pkg::OP_LOAD;
         if ($urandom_range(3) != 0)
            r.prime = segps_pkg::PRIME_W'(small_primes[$urandom_range(9)]);
      end else if (pick < 50) r.op = OP_UNUSED;
      return r;
   endfunction

   initial begin
      failures = 0; sieves_sent = 0; results_seen = 0; items_sent = 0;
      mirror_count = 0; cycles = 0;
      sender_idle_pct = 0; receiver_stall_pct = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part
      queue_row(mk_typed(48'd0, 7'd1, '{value: 0, found: 0, last: 1}));
      queue_row(mk_typed(48'd2, 7'd1, '{value: 2, found: 1, last: 1}));
      queue_row(mk(OP_UNUSED, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF, 7'h7F));
      queue_row(mk(segps_pkg::OP_LOAD, 24'd2, '0, '0));
      queue_row(mk(segps_pkg::OP_LOAD, 24'd3, '0, '0));
      queue_row(mk(segps_pkg::OP_LOAD, 24'd5, '0, '0));
      queue_row(mk(segps_pkg::OP_LOAD, 24'd7, '0, '0));
      queue_row(mk(segps_pkg::OP_LOAD, 24'd0, '0, '0));
      queue_row(mk(segps_pkg::OP_LOAD, 24'd1, '0, '0));
      queue_row(mk(segps_pkg::OP_SIEVE, '0, 48'd0, 7'd64));
      queue_row(mk_typed(48'd10, 7'd0, '{value: 0, found: 0, last: 1}));
      queue_row(mk_typed(48'd24, 7'd5, '{value: 0, found: 0, last: 1}));
      queue_row(mk(segps_pkg::OP_SIEVE, '0, 48'd100, 7'd127));
      queue_row(mk(segps_pkg::OP_SIEVE, '0, 48'hFFFF_FFFF_FFFD, 7'd10));
      queue_row(mk(segps_pkg::OP_LOAD, 24'hFFFFFF, '0, '0));
      queue_row(mk(segps_pkg::OP_SIEVE, '0, 48'hFFFF_FFFF_FFC0, 7'd64));
      queue_row(mk(segps_pkg::OP_SIEVE, '0, 48'hFFFF_FFFF_FFFF, 7'd1));
      queue_row(mk(segps_pkg::OP_CLEAR, '0, '0, '0));
      queue_row(mk(segps_pkg::OP_SIEVE, '0, 48'd0, 7'd100));
      queue_row(mk(segps_pkg::OP_LOAD, 24'd3, '0, '0));
      queue_row(mk_typed(48'd9, 7'd1, '{value: 0, found: 0, last: 1}));
      queue_row(mk_typed(48'd3, 7'd1, '{value: 3, found: 1, last: 1}));
      foreach (stim_rows[i]) send_item(stim_rows[i]);

      // Hold off until the directed results are all back
      drain_idle();

      // Random part, cycling through idle and stall mixes
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ((n / 20) % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
            default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
         endcase
         send_item(random_row());
      end
      drain_idle();
      repeat (300) @(posedge clock);

      $display("Covered %0d items, %0d segment sieves, %0d results checked,", items_sent,
               sieves_sent, results_seen);
      $display("with idle and stall mixes and segments at both ends of the value range.");
      if (failures == 0 && pending_survivors.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
